// File: hw/rtl/pncr_pkg.sv
// ----------------------------------------------------------------------------
// pncr_pkg
// Shared types, constants and microcode ROM for the pink noise channel
// rotator: datapath widths, filter coefficients and the control program.
// ----------------------------------------------------------------------------
package pncr_pkg;

    localparam int unsigned MAX_CHANNELS = 64;

    localparam int CH_W    = 6;
    localparam int CNT_W   = 7;
    localparam int STEP_W  = 24;
    localparam int SAMP_W  = 16;
    localparam int ACC_W   = 32;
    localparam int SUM_W   = 34;
    localparam int COEF_W  = 25;
    localparam int PROD_W  = 60;
    localparam int DECAY_W = 33;
    localparam int DRV_W   = 26;
    localparam int GAIN_W  = 27;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 24;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT    = 2'd0;
    localparam logic [IDX_W-1:0] REG_SAMPLES_PER_STEP = 2'd1;
    localparam logic [IDX_W-1:0] REG_BUS_CHANNELS     = 2'd2;

    localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT    = 7'd1;
    localparam logic [STEP_W-1:0] RST_SAMPLES_PER_STEP = 24'd48000;
    localparam logic [CNT_W-1:0]  RST_BUS_CHANNELS     = 7'd64;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_FIRST = 4'd1;
    localparam step_t STEP_LAST  = 4'd10;

    typedef enum logic [2:0] {
        OPA_WHITE,
        OPA_SLOW,
        OPA_MID,
        OPA_FAST,
        OPA_SUM
    } opa_t;

    typedef enum logic [2:0] {
        COEF_DIRECT,
        COEF_P_SLOW,
        COEF_W_SLOW,
        COEF_P_MID,
        COEF_W_MID,
        COEF_P_FAST,
        COEF_W_FAST,
        COEF_GAIN
    } coef_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DIRECT,
        ACT_DECAY,
        ACT_DRIVE,
        ACT_GAIN
    } act_t;

    typedef enum logic [1:0] {
        POLE_SLOW,
        POLE_MID,
        POLE_FAST
    } pole_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT,
        JMP_HOME
    } jmp_t;

    typedef struct packed {
        logic  mul_en;
        opa_t  opa;
        coef_t coef;
        act_t  act;
        pole_t dst;
        logic  div_en;
        jmp_t  jmp;
    } uword_t;

    function automatic logic [COEF_W-1:0] coef_value(input coef_t c);
        logic [COEF_W-1:0] v;
        case (c)
            COEF_DIRECT: v = 25'd3100430;
            COEF_P_SLOW: v = 25'd16737790;
            COEF_W_SLOW: v = 25'd1661716;
            COEF_P_MID:  v = 25'd16156459;
            COEF_W_MID:  v = 25'd4974720;
            COEF_P_FAST: v = 25'd9563013;
            COEF_W_FAST: v = 25'd17661229;
            COEF_GAIN:   v = 25'd977239;
            default:     v = '0;
        endcase
        return v;
    endfunction

    // control program: one word per step
    function automatic uword_t ucode(input step_t s);
        uword_t u;
        u = '{mul_en: 1'b0, opa: OPA_WHITE, coef: COEF_DIRECT, act: ACT_NONE,
              dst: POLE_SLOW, div_en: 1'b0, jmp: JMP_NEXT};
        case (s)
            4'd0: begin
                u.jmp = JMP_WAIT_IN;
            end
            4'd1: begin
                u.mul_en = 1'b1; u.opa = OPA_WHITE; u.coef = COEF_DIRECT;
                u.div_en = 1'b1;
            end
            4'd2: begin
                u.mul_en = 1'b1; u.opa = OPA_SLOW; u.coef = COEF_P_SLOW;
                u.act = ACT_DIRECT; u.div_en = 1'b1;
            end
            4'd3: begin
                u.mul_en = 1'b1; u.opa = OPA_WHITE; u.coef = COEF_W_SLOW;
                u.act = ACT_DECAY; u.div_en = 1'b1;
            end
            4'd4: begin
                u.mul_en = 1'b1; u.opa = OPA_MID; u.coef = COEF_P_MID;
                u.act = ACT_DRIVE; u.dst = POLE_SLOW; u.div_en = 1'b1;
            end
            4'd5: begin
                u.mul_en = 1'b1; u.opa = OPA_WHITE; u.coef = COEF_W_MID;
                u.act = ACT_DECAY; u.div_en = 1'b1;
            end
            4'd6: begin
                u.mul_en = 1'b1; u.opa = OPA_FAST; u.coef = COEF_P_FAST;
                u.act = ACT_DRIVE; u.dst = POLE_MID; u.div_en = 1'b1;
            end
            4'd7: begin
                u.mul_en = 1'b1; u.opa = OPA_WHITE; u.coef = COEF_W_FAST;
                u.act = ACT_DECAY; u.div_en = 1'b1;
            end
            4'd8: begin
                u.act = ACT_DRIVE; u.dst = POLE_FAST;
            end
            4'd9: begin
                u.mul_en = 1'b1; u.opa = OPA_SUM; u.coef = COEF_GAIN;
            end
            4'd10: begin
                u.act = ACT_GAIN; u.jmp = JMP_WAIT_OUT;
            end
            default: begin
                u.jmp = JMP_HOME;
            end
        endcase
        return u;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [ACC_W-1:0] r;
        if (x[SUM_W-1:ACC_W-1] == '0 || x[SUM_W-1:ACC_W-1] == '1) begin
            r = x[ACC_W-1:0];
        end else if (x[SUM_W-1]) begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SAMP_W-1:0] sat16(input logic signed [GAIN_W-1:0] x);
        logic signed [SAMP_W-1:0] r;
        if (x[GAIN_W-1:SAMP_W-1] == '0 || x[GAIN_W-1:SAMP_W-1] == '1) begin
            r = x[SAMP_W-1:0];
        end else if (x[GAIN_W-1]) begin
            r = {1'b1, {(SAMP_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMP_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/pink_noise_channel_rotator_core.sv
// ----------------------------------------------------------------------------
// pink_noise_channel_rotator_core
// Speaker-test pink noise generator with channel rotation.
//
// Usage:
//   s_ carries one white noise sample (Q1.15) per transaction. m_ returns one
//   result per sample: target channel, pink sample, next active channel, and
//   in m_tuser whether the target channel exists on the bus.
//   cfg_ writes channel_count (0), samples_per_step (1), bus_channels (2);
//   cfg_ready is high outside reset, writes are meant for idle periods only.
// Timing:
//   A sample runs through a ten step microprogram that drives one shared
//   26x34 multiplier for eight products; the result is loaded into the
//   output register in the final step, and no new sample is accepted until
//   the sequencer is back in its idle step. Channel wrap uses a 7 step
//   remainder unit running alongside the filter steps.
// Reset: aresetn (synchronous, low) clears the filters, the step counter and
//   the active channel, and loads the register defaults.
// Stall: a result waits in the output register; the sequencer can take and
//   process one more sample, then holds in its final step until m_tready.
// ----------------------------------------------------------------------------
module pink_noise_channel_rotator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: [15:0] white_sample
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pncr_pkg::SAMP_W-1:0]      s_tdata,
    // m_tdata: [5:0] target_channel, [21:6] pink_value,
    //          [27:22] next_active_channel, [31:28] zero
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,
    // m_tuser: [0] channel_present
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pncr_pkg::IDX_W-1:0]       cfg_index,
    input  logic [pncr_pkg::CFG_W-1:0]       cfg_data
);
    import pncr_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF15 = PROD_W'(1) << 14;
    localparam logic signed [PROD_W-1:0] HALF24 = PROD_W'(1) << 23;
    localparam logic signed [PROD_W-1:0] HALF33 = PROD_W'(1) << 32;

    // configuration
    logic [CNT_W-1:0]  chan_count_reg;
    logic [STEP_W-1:0] step_len_reg;
    logic [CNT_W-1:0]  bus_ch_reg;

    // sequencer
    step_t  pc_reg, pc_next;
    uword_t uw;

    // datapath
    logic signed [SAMP_W-1:0]  w_reg;
    logic signed [ACC_W-1:0]   slow_reg, mid_reg, fast_reg;
    logic signed [DECAY_W-1:0] part_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SUM_W-1:0]   opa_val;
    logic [COEF_W-1:0]         coef_val;
    logic signed [PROD_W-1:0]  r15, r24, r33;
    logic signed [DRV_W-1:0]   drive_val;
    logic signed [DECAY_W-1:0] decay_val;
    logic signed [GAIN_W-1:0]  gain_val;
    logic signed [SUM_W-1:0]   drive_sum;
    logic signed [ACC_W-1:0]   new_acc;

    // channel control
    logic [STEP_W-1:0] samples_in_step_reg;
    logic [CH_W-1:0]   active_channel_reg;
    logic [CH_W-1:0]   target_reg;
    logic              present_reg;
    logic              advance_reg;
    logic [CNT_W-1:0]  dvd_reg, rem_reg, divisor_reg;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W-1:0]  rem_next;
    logic [STEP_W:0]   samples_inc;
    logic [STEP_W-1:0] step_len_eff;
    logic              advance_now;
    logic [CNT_W-1:0]  count_eff;
    logic [CH_W-1:0]   active_next;

    // output register
    logic                    m_tvalid_reg;
    logic [CH_W-1:0]         out_target_reg;
    logic [SAMP_W-1:0]       out_pink_reg;
    logic                    out_present_reg;
    logic [CH_W-1:0]         out_next_reg;

    logic in_accept, out_free, out_load;

    assign uw        = ucode(pc_reg);
    assign s_tready  = aresetn && (uw.jmp == JMP_WAIT_IN);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (uw.act == ACT_GAIN) && out_free;
    assign cfg_ready = aresetn;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_next_reg, out_pink_reg, out_target_reg};
    assign m_tuser  = out_present_reg;

    // sequencer next step
    always_comb begin
        case (uw.jmp)
            JMP_NEXT:     pc_next = step_t'(pc_reg + 1'b1);
            JMP_WAIT_IN:  pc_next = in_accept ? step_t'(pc_reg + 1'b1) : pc_reg;
            JMP_WAIT_OUT: pc_next = out_free ? STEP_IDLE : pc_reg;
            JMP_HOME:     pc_next = STEP_IDLE;
            default:      pc_next = STEP_IDLE;
        endcase
    end

    // multiplier operands
    always_comb begin
        case (uw.opa)
            OPA_WHITE: opa_val = SUM_W'(w_reg);
            OPA_SLOW:  opa_val = SUM_W'(slow_reg);
            OPA_MID:   opa_val = SUM_W'(mid_reg);
            OPA_FAST:  opa_val = SUM_W'(fast_reg);
            OPA_SUM:   opa_val = sum_reg;
            default:   opa_val = '0;
        endcase
    end

    assign coef_val  = coef_value(uw.coef);
    assign prod_next = opa_val * $signed({1'b0, coef_val});

    // rounding of the registered product
    assign r15       = prod_reg + HALF15;
    assign r24       = prod_reg + HALF24;
    assign r33       = prod_reg + HALF33;
    assign drive_val = r15[15+DRV_W-1:15];
    assign decay_val = r24[24+DECAY_W-1:24];
    assign gain_val  = r33[33+GAIN_W-1:33];
    assign drive_sum = SUM_W'(part_reg) + SUM_W'(drive_val);
    assign new_acc   = sat32(drive_sum);

    // step bookkeeping at acceptance
    always_comb begin
        step_len_eff = (step_len_reg == '0) ? STEP_W'(1) : step_len_reg;
        samples_inc  = {1'b0, samples_in_step_reg} + 1'b1;
        advance_now  = (samples_inc >= {1'b0, step_len_eff});
        if (chan_count_reg == '0) begin
            count_eff = CNT_W'(1);
        end else if (chan_count_reg > CNT_W'(MAX_CHANNELS)) begin
            count_eff = CNT_W'(MAX_CHANNELS);
        end else begin
            count_eff = chan_count_reg;
        end
    end

    // restoring remainder, one bit per step
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[CNT_W-1]};
        if (rem_shift >= {1'b0, divisor_reg}) begin
            rem_shift = rem_shift - {1'b0, divisor_reg};
        end
        rem_next = rem_shift[CNT_W-1:0];
    end

    assign active_next = advance_reg ? rem_reg[CH_W-1:0] : active_channel_reg;

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg              <= STEP_IDLE;
            chan_count_reg      <= RST_CHANNEL_COUNT;
            step_len_reg        <= RST_SAMPLES_PER_STEP;
            bus_ch_reg          <= RST_BUS_CHANNELS;
            slow_reg            <= '0;
            mid_reg             <= '0;
            fast_reg            <= '0;
            samples_in_step_reg <= '0;
            active_channel_reg  <= '0;
            m_tvalid_reg        <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CHANNEL_COUNT:    chan_count_reg <= cfg_data[CNT_W-1:0];
                    REG_SAMPLES_PER_STEP: step_len_reg   <= cfg_data[STEP_W-1:0];
                    REG_BUS_CHANNELS:     bus_ch_reg     <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                samples_in_step_reg <= advance_now ? '0 : samples_inc[STEP_W-1:0];
            end
            if (uw.act == ACT_DRIVE) begin
                case (uw.dst)
                    POLE_SLOW: slow_reg <= new_acc;
                    POLE_MID:  mid_reg  <= new_acc;
                    POLE_FAST: fast_reg <= new_acc;
                    default: ;
                endcase
            end
            if (out_load) begin
                active_channel_reg <= active_next;
                m_tvalid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            w_reg       <= s_tdata;
            target_reg  <= active_channel_reg;
            present_reg <= ({1'b0, active_channel_reg} < bus_ch_reg);
            advance_reg <= advance_now;
            dvd_reg     <= CNT_W'({1'b0, active_channel_reg} + 1'b1);
            rem_reg     <= '0;
            divisor_reg <= count_eff;
        end else if (uw.div_en) begin
            dvd_reg <= {dvd_reg[CNT_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (uw.mul_en) begin
            prod_reg <= prod_next;
        end
        case (uw.act)
            ACT_DIRECT: sum_reg  <= SUM_W'(drive_val);
            ACT_DECAY:  part_reg <= decay_val;
            ACT_DRIVE:  sum_reg  <= sum_reg + SUM_W'(new_acc);
            default: ;
        endcase
        if (out_load) begin
            out_target_reg  <= target_reg;
            out_pink_reg    <= present_reg ? sat16(gain_val) : '0;
            out_present_reg <= present_reg;
            out_next_reg    <= active_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_program: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> pc_reg == STEP_FIRST)
        else $error("accepted sample did not start the program");

    a_absent_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tdata[21:6] == '0)
        else $error("absent channel carries a nonzero sample");

    a_remainder_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && advance_reg) |-> rem_reg < divisor_reg)
        else $error("channel wrap remainder out of range");

    a_next_channel_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && m_tdata[27:22] == active_channel_reg)
        else $error("reported next channel differs from active channel");
`endif

endmodule

// File: verif/pink_noise_channel_rotator_core_tb.sv
// ----------------------------------------------------------------------------
// pink_noise_channel_rotator_core_tb
// Self-checking bench for the pink noise channel rotator. A directed table
// covers sample extremes, register limits, absent channels and shrunken
// count and step settings. Random phases follow with random register
// settings, long runs of extreme samples to drive the output into
// saturation, random gaps on both streams and one long output stall.
// Every result transaction is compared with a bit-exact fixed-point model
// of the filters and the channel rotation, or with a table row's expected result.
// ----------------------------------------------------------------------------
module pink_noise_channel_rotator_core_tb;

    localparam logic [pncr_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint K_POLE_SLOW  = 16737790;
    localparam longint K_POLE_MID   = 16156459;
    localparam longint K_POLE_FAST  = 9563013;
    localparam longint K_DRV_SLOW   = 1661716;
    localparam longint K_DRV_MID    = 4974720;
    localparam longint K_DRV_FAST   = 17661229;
    localparam longint K_DIRECT     = 3100430;
    localparam longint K_GAIN       = 977239;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 60;

    typedef struct packed {
        logic [5:0]         target;
        logic signed [15:0] pink;
        logic               present;
        logic [5:0]         next_ch;
    } pink_result_t;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [pncr_pkg::IDX_W-1:0] idx;
        logic [23:0]                data;
        logic [15:0]                w;
        bit                         typed;
        pink_result_t               want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [pncr_pkg::IDX_W-1:0] cfg_index = '0;
    logic [pncr_pkg::CFG_W-1:0] cfg_data = '0;

    // model state
    logic signed [31:0] slow_acc, mid_acc, fast_acc;
    logic [24:0]        step_count;
    logic [5:0]         active_ch;
    logic [6:0]         chan_count_reg;
    logic [23:0]        step_len_reg;
    logic [6:0]         bus_chan_reg;

    pink_result_t pending_results[$];
    int  error_count = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    bit  hold_req = 1'b0;

    pink_noise_channel_rotator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic signed [31:0] pole_next(input logic signed [31:0] acc,
                                                     input longint pole, input longint drv,
                                                     input longint w);
        longint decay, drive, total;
        decay = (pole * longint'(acc) + (64'sd1 <<< 23)) >>> 24;
        drive = (drv * w + (64'sd1 <<< 14)) >>> 15;
        total = decay + drive;
        if (total > 64'sd2147483647)
            total = 64'sd2147483647;
        if (total < -64'sd2147483648)
            total = -64'sd2147483648;
        return total[31:0];
    endfunction

    function automatic pink_result_t pink_predict(input logic [15:0] sample);
        pink_result_t r;
        longint w, sum, scaled;
        int count, step_len;
        w = longint'($signed(sample));
        slow_acc = pole_next(slow_acc, K_POLE_SLOW, K_DRV_SLOW, w);
        mid_acc  = pole_next(mid_acc, K_POLE_MID, K_DRV_MID, w);
        fast_acc = pole_next(fast_acc, K_POLE_FAST, K_DRV_FAST, w);
        sum = longint'(slow_acc) + longint'(mid_acc) + longint'(fast_acc)
            + ((K_DIRECT * w + (64'sd1 <<< 14)) >>> 15);
        scaled = (sum * K_GAIN + (64'sd1 <<< 32)) >>> 33;
        if (scaled > 32767)
            scaled = 32767;
        if (scaled < -32768)
            scaled = -32768;
        r.target  = active_ch;
        r.present = (int'(active_ch) < int'(bus_chan_reg));
        r.pink    = r.present ? scaled[15:0] : '0;
        count = (chan_count_reg == 0) ? 1 : int'(chan_count_reg);
        if (count > int'(pncr_pkg::MAX_CHANNELS))
            count = pncr_pkg::MAX_CHANNELS;
        step_len = (step_len_reg == 0) ? 1 : int'(step_len_reg);
        step_count = step_count + 25'd1;
        if (int'(step_count) >= step_len) begin
            step_count = '0;
            active_ch = 6'((int'(active_ch) + 1) % count);
        end
        r.next_ch = active_ch;
        return r;
    endfunction

    function automatic int draw_wait(input bit on);
        return on ? int'($urandom_range(0, 9)) : 0;
    endfunction

    function automatic stim_row_t cfg_row(input logic [pncr_pkg::IDX_W-1:0] idx,
                                          input logic [23:0] data);
        stim_row_t r;
        r = '{kind: ROW_CFG, idx: idx, data: data, w: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t smp_row(input logic [15:0] w);
        stim_row_t r;
        r = '{kind: ROW_SAMPLE, idx: '0, data: '0, w: w, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t chk_row(input logic [15:0] w, input pink_result_t want);
        stim_row_t r;
        r = '{kind: ROW_SAMPLE, idx: '0, data: '0, w: w, typed: 1'b1, want: want};
        return r;
    endfunction

    // more: the next transaction follows directly, so tvalid may stay high
    task automatic push_sample(input logic [15:0] w, input bit more, input bit typed,
                               input pink_result_t want);
        pink_result_t got;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        got = pink_predict(w);
        pending_results.push_back(typed ? want : got);
        gap = draw_wait(send_idle_on);
        if (!more || gap > 0)
            s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [pncr_pkg::IDX_W-1:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            pncr_pkg::REG_CHANNEL_COUNT:    chan_count_reg = data[6:0];
            pncr_pkg::REG_SAMPLES_PER_STEP: step_len_reg   = data;
            pncr_pkg::REG_BUS_CHANNELS:     bus_chan_reg   = data[6:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // result side: per-transaction stall, one long hold-off on request
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = draw_wait(recv_idle_on);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        pink_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result with none pending, tdata %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[5:0] !== want.target)
                    flag_error($sformatf("target_channel %0d, want %0d",
                                         m_tdata[5:0], want.target));
                if (m_tdata[21:6] !== want.pink)
                    flag_error($sformatf("pink_value %0d, want %0d",
                                         $signed(m_tdata[21:6]), want.pink));
                if (m_tuser !== want.present)
                    flag_error($sformatf("channel_present %b, want %b",
                                         m_tuser, want.present));
                if (m_tdata[27:22] !== want.next_ch)
                    flag_error($sformatf("next_active_channel %0d, want %0d",
                                         m_tdata[27:22], want.next_ch));
                if (m_tdata[31:28] !== 4'h0)
                    flag_error($sformatf("tdata pad bits %h", m_tdata[31:28]));
            end
        end
    end

    initial begin : watchdog
        #(4_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        stim_row_t    rows[$];
        logic [15:0]  w;
        logic [23:0]  cnt_val, step_val, bus_val;
        int           sent, phase_no, phase_len, burst_len, mode, k;
        bit           more;

        slow_acc       = '0;
        mid_acc        = '0;
        fast_acc       = '0;
        step_count     = '0;
        active_ch      = '0;
        chan_count_reg = pncr_pkg::RST_CHANNEL_COUNT;
        step_len_reg   = pncr_pkg::RST_SAMPLES_PER_STEP;
        bus_chan_reg   = pncr_pkg::RST_BUS_CHANNELS;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = '{
            chk_row(16'h0000, '{target: 6'd0, pink: 16'sd0, present: 1'b1, next_ch: 6'd0}),
            smp_row(16'h7FFF),
            smp_row(16'h8000),
            smp_row(16'h0001),
            smp_row(16'hFFFF),
            cfg_row(REG_UNUSED, 24'hFFFFFF),
            smp_row(16'h7FFF),
            cfg_row(pncr_pkg::REG_CHANNEL_COUNT, 24'h000000),
            cfg_row(pncr_pkg::REG_SAMPLES_PER_STEP, 24'h000000),
            smp_row(16'h1234),
            cfg_row(pncr_pkg::REG_CHANNEL_COUNT, 24'hFFFFFF),
            smp_row(16'h8001),
            smp_row(16'h5555),
            smp_row(16'hAAAA),
            cfg_row(pncr_pkg::REG_BUS_CHANNELS, 24'h000000),
            chk_row(16'h7FFF, '{target: 6'd3, pink: 16'sd0, present: 1'b0, next_ch: 6'd4}),
            cfg_row(pncr_pkg::REG_BUS_CHANNELS, 24'h00007F),
            cfg_row(pncr_pkg::REG_CHANNEL_COUNT, 24'h000002),
            smp_row(16'h8000),
            cfg_row(pncr_pkg::REG_SAMPLES_PER_STEP, 24'h000003),
            smp_row(16'h0100),
            smp_row(16'hFF00),
            cfg_row(pncr_pkg::REG_SAMPLES_PER_STEP, 24'h000001),
            smp_row(16'h7FFF),
            cfg_row(pncr_pkg::REG_BUS_CHANNELS, 24'h000001),
            smp_row(16'h0000),
            smp_row(16'h7FFF),
            cfg_row(pncr_pkg::REG_SAMPLES_PER_STEP, 24'hFFFFFF),
            cfg_row(pncr_pkg::REG_CHANNEL_COUNT, 24'h000040),
            cfg_row(pncr_pkg::REG_BUS_CHANNELS, 24'h000040),
            smp_row(16'h4000)
        };

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                more = (i + 1 < rows.size()) && (rows[i + 1].kind == ROW_SAMPLE);
                push_sample(rows[i].w, more, rows[i].typed, rows[i].want);
            end
        end

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0:       cnt_val = 24'd0;
                1:       cnt_val = 24'd1;
                2:       cnt_val = 24'd64;
                3:       cnt_val = 24'($urandom_range(65, 127));
                default: cnt_val = 24'($urandom_range(2, 63));
            endcase
            case ($urandom_range(0, 7))
                0:       step_val = 24'd0;
                1:       step_val = 24'd1;
                2:       step_val = 24'hFFFFFF;
                default: step_val = 24'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 4))
                0:       bus_val = 24'd0;
                1:       bus_val = 24'd64;
                2:       bus_val = 24'($urandom_range(65, 127));
                default: bus_val = 24'($urandom_range(1, 63));
            endcase
            // junk in the bits above each register's width
            write_reg(pncr_pkg::REG_CHANNEL_COUNT, cnt_val | (24'($urandom) & 24'hFFFF80));
            write_reg(pncr_pkg::REG_SAMPLES_PER_STEP, step_val);
            write_reg(pncr_pkg::REG_BUS_CHANNELS, bus_val | (24'($urandom) & 24'hFFFF80));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 24'($urandom));

            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if (phase_no == 1) begin
                send_idle_on = 1'b0;
                hold_req = 1'b1;
            end

            phase_len = $urandom_range(40, 90);
            k = 0;
            while (k < phase_len) begin
                mode = $urandom_range(0, 3);
                burst_len = (mode == 1 || mode == 2) ? $urandom_range(60, 180)
                                                      : $urandom_range(1, 40);
                repeat (burst_len) begin
                    case (mode)
                        0: w = 16'($urandom);
                        1: w = 16'h7FFF - 16'($urandom_range(0, 200));
                        2: w = 16'h8000 + 16'($urandom_range(0, 200));
                        default: w = 16'($signed(9'($urandom)));
                    endcase
                    k++;
                    sent++;
                    push_sample(w, k < phase_len, 1'b0, '0);
                    if (k >= phase_len)
                        break;
                end
            end
            phase_no++;
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/pncr_pkg.sv
hw/rtl/pink_noise_channel_rotator_core.sv
verif/pink_noise_channel_rotator_core_tb.sv
